### design/debug_breakpoint_slot_table_core_defines.svh
// Assertion macros for the breakpoint slot table core.
// Used by the top level only; no other dependencies.
`ifndef DEBUG_BREAKPOINT_SLOT_TABLE_CORE_DEFINES_SVH
`define DEBUG_BREAKPOINT_SLOT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DBST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("breakpoint slot table: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DBST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("breakpoint slot table: next-cycle check failed");

`endif

### design/dbst_pkg.sv
// Shared types and constants for the breakpoint slot table.
// No dependencies.
package dbst_pkg;

    localparam int SLOT_COUNT  = 4;
    localparam int SLOT_IDX_W  = 2;
    localparam int COUNT_W     = $clog2(SLOT_COUNT + 1);
    localparam int ADDR_W      = 32;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_FIND = 2'd1,
        OP_FREE = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_BAD_SCOPE = 3'd3,
        ST_NO_FREE   = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_NOT_USED  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        SCOPE_LOCAL  = 2'd1,
        SCOPE_GLOBAL = 2'd2
    } t_scope;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

### design/debug_breakpoint_slot_table_core.sv
// Top level of the breakpoint slot table: controller plus datapath.
// Depends on dbst_pkg, dbst_ctrl, dbst_datapath and the defines header.
//
// Each command beat (start high while busy is low) is registered in S_IDLE;
// in S_EXEC the four slot range comparators and the free stack update run.
// The result appears on o_status/o_slot_index with o_done, high for exactly
// one cycle, in the cycle after S_EXEC; busy is low again then, so a new
// command may be issued in that same cycle. No new command is taken while
// busy is high. The receiver cannot stall the result.
`include "debug_breakpoint_slot_table_core_defines.svh"
module debug_breakpoint_slot_table_core
    import dbst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_opcode,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [2:0]            i_access_type,
    input  logic [2:0]            i_size_code,
    input  logic [1:0]            i_scope,
    input  logic [SLOT_IDX_W-1:0] i_slot,
    output logic                  o_done,
    output logic [2:0]            o_status,
    output logic [SLOT_IDX_W-1:0] o_slot_index
);

    t_dp_cmd w_cmd;

    dbst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    dbst_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_opcode      (i_opcode),
        .i_address     (i_address),
        .i_access_type (i_access_type),
        .i_size_code   (i_size_code),
        .i_scope       (i_scope),
        .i_slot        (i_slot),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index)
    );

    // Accepted beat gives a result strobe after its S_EXEC state
    `DBST_ASSERT_NOW(a_accept_done, i_clk, i_rst_n, start && !busy, ##2 o_done)
    // Busy lasts one cycle only
    `DBST_ASSERT_NEXT(a_busy_short, i_clk, i_rst_n, busy, !busy)
    // Result is shown while idle
    `DBST_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // Failed operations report slot zero
    `DBST_ASSERT_NOW(a_fail_index, i_clk, i_rst_n, o_done && o_status != ST_OK, o_slot_index == '0)

endmodule

### design/dbst_ctrl.sv
// Controller for the breakpoint slot table: command accept and result strobe.
// Depends on dbst_pkg.
module dbst_ctrl
    import dbst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    output logic    o_done,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_done;

    // State register and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

### design/dbst_datapath.sv
// Datapath for the breakpoint slot table: slot storage, free stack,
// range comparators and result registers. Depends on dbst_pkg.
module dbst_datapath
    import dbst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [1:0]            i_opcode,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [2:0]            i_access_type,
    input  logic [2:0]            i_size_code,
    input  logic [1:0]            i_scope,
    input  logic [SLOT_IDX_W-1:0] i_slot,
    output logic [2:0]            o_status,
    output logic [SLOT_IDX_W-1:0] o_slot_index
);

    // Captured command beat
    logic [1:0]            r_op;
    logic [ADDR_W-1:0]     r_addr;
    logic [2:0]            r_kind;
    logic [2:0]            r_size;
    logic [1:0]            r_scope;
    logic [SLOT_IDX_W-1:0] r_slot;

    // Slot table
    logic [ADDR_W-1:0]     r_base     [SLOT_COUNT];
    logic [1:0]            r_slot_kind[SLOT_COUNT];
    logic [1:0]            r_len_code [SLOT_COUNT];
    logic                  r_global   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_in_use;

    // Free stack
    logic [SLOT_IDX_W-1:0] r_stack[SLOT_COUNT];
    logic [COUNT_W-1:0]    r_free_count;
    logic [COUNT_W-1:0]    w_top;

    // Results
    logic [2:0]            r_status;
    logic [SLOT_IDX_W-1:0] r_index;
    logic [2:0]            n_status;
    logic [SLOT_IDX_W-1:0] n_index;

    logic                  w_set_ok;
    logic                  w_free_ok;
    logic [SLOT_IDX_W-1:0] w_alloc;
    logic [SLOT_COUNT-1:0] w_hit;
    logic [ADDR_W-1:0]     w_diff[SLOT_COUNT];

    assign w_top   = r_free_count - COUNT_W'(1);
    assign w_alloc = r_stack[w_top[SLOT_IDX_W-1:0]];

    // Compare the query against every slot range, no wrap
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_diff[i] = r_addr - r_base[i];
            w_hit[i]  = r_in_use[i] && ({1'b0, r_slot_kind[i]} == r_kind)
                        && (r_addr >= r_base[i])
                        && ((w_diff[i] >> r_len_code[i]) == '0);
        end
    end

    // Decode the operation and pick the result
    always_comb begin
        n_status  = ST_OK;
        n_index   = '0;
        w_set_ok  = 1'b0;
        w_free_ok = 1'b0;
        unique case (t_opcode'(r_op))
            OP_SET: begin
                if (r_size > 3'd3) begin
                    n_status = ST_BAD_SIZE;
                end else if (r_kind > 3'd3) begin
                    n_status = ST_BAD_TYPE;
                end else if (r_scope != SCOPE_LOCAL && r_scope != SCOPE_GLOBAL) begin
                    n_status = ST_BAD_SCOPE;
                end else if (r_free_count == '0) begin
                    n_status = ST_NO_FREE;
                end else begin
                    w_set_ok = 1'b1;
                    n_index  = w_alloc;
                end
            end
            OP_FIND: begin
                n_status = ST_NOT_FOUND;
                // Lowest-numbered hit wins
                for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                    if (w_hit[i]) begin
                        n_status = ST_OK;
                        n_index  = SLOT_IDX_W'(i);
                    end
                end
            end
            OP_FREE: begin
                if (!r_in_use[r_slot]) begin
                    n_status = ST_NOT_USED;
                end else begin
                    w_free_ok = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Control state: use flags and free stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use     <= '0;
            r_free_count <= COUNT_W'(SLOT_COUNT);
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_stack[i] <= SLOT_IDX_W'(i);
            end
        end else if (i_cmd.exec) begin
            if (w_set_ok) begin
                r_in_use[w_alloc] <= 1'b1;
                r_free_count      <= w_top;
            end
            if (w_free_ok) begin
                r_in_use[r_slot] <= 1'b0;
                if (r_free_count < COUNT_W'(SLOT_COUNT)) begin
                    r_stack[r_free_count[SLOT_IDX_W-1:0]] <= r_slot;
                    r_free_count <= r_free_count + COUNT_W'(1);
                end
            end
        end
    end

    // Payload: command capture, slot fields, results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_addr  <= i_address;
            r_kind  <= i_access_type;
            r_size  <= i_size_code;
            r_scope <= i_scope;
            r_slot  <= i_slot;
        end
        if (i_cmd.exec) begin
            if (w_set_ok) begin
                r_base[w_alloc]      <= r_addr;
                r_slot_kind[w_alloc] <= r_kind[1:0];
                r_len_code[w_alloc]  <= r_size[1:0];
                r_global[w_alloc]    <= (r_scope == SCOPE_GLOBAL);
            end
            if (w_free_ok) begin
                r_base[r_slot]      <= '0;
                r_slot_kind[r_slot] <= '0;
                r_len_code[r_slot]  <= '0;
                r_global[r_slot]    <= 1'b0;
            end
            r_status <= n_status;
            r_index  <= n_index;
        end
    end

    assign o_status     = r_status;
    assign o_slot_index = r_index;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the breakpoint slot table core: directed table, then random beats.
// Depends on dbst_pkg and debug_breakpoint_slot_table_core; predicts results internally, fixed rows excepted.
module tb_top;
    import dbst_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 700;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_REPORTS   = 10;

    // Access types and size codes as the command fields carry them
    localparam logic [2:0] KIND_EXEC    = 3'd0;
    localparam logic [2:0] KIND_WRITE   = 3'd1;
    localparam logic [2:0] KIND_IO      = 3'd2;
    localparam logic [2:0] KIND_RW      = 3'd3;
    localparam logic [2:0] KIND_BAD_LO  = 3'd4;
    localparam logic [2:0] KIND_BAD_MID = 3'd5;
    localparam logic [2:0] KIND_BAD_HI  = 3'd7;
    localparam logic [2:0] SIZE_1B      = 3'd0;
    localparam logic [2:0] SIZE_2B      = 3'd1;
    localparam logic [2:0] SIZE_4B      = 3'd2;
    localparam logic [2:0] SIZE_8B      = 3'd3;
    localparam logic [2:0] SIZE_BAD_HI  = 3'd7;
    localparam logic [1:0] SCOPE_NONE   = 2'd0;
    localparam logic [1:0] SCOPE_BOTH   = 2'd3;

    localparam logic [ADDR_W-1:0] CLUSTER_BASE = 32'h0000_1000;
    localparam logic [ADDR_W-1:0] ADDR_TOP     = '1;

    typedef struct packed {
        t_opcode                opcode;
        logic [ADDR_W-1:0]      address;
        logic [2:0]             access_type;
        logic [2:0]             size_code;
        logic [1:0]             scope;
        logic [SLOT_IDX_W-1:0]  slot;
    } t_bp_cmd;

    typedef struct packed {
        t_status                status;
        logic [SLOT_IDX_W-1:0]  slot_index;
    } t_bp_resp;

    typedef struct {
        t_bp_cmd  cmd;
        bit       fixed;
        t_bp_resp resp;
    } t_bp_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_opcode;
    logic [ADDR_W-1:0]     i_address;
    logic [2:0]            i_access_type;
    logic [2:0]            i_size_code;
    logic [1:0]            i_scope;
    logic [SLOT_IDX_W-1:0] i_slot;
    logic                  o_done;
    logic [2:0]            o_status;
    logic [SLOT_IDX_W-1:0] o_slot_index;

    // Shadow copy of the slot table
    logic [ADDR_W-1:0]     bp_base       [SLOT_COUNT];
    logic [1:0]            bp_kind       [SLOT_COUNT];
    logic [1:0]            bp_len_code   [SLOT_COUNT];
    logic                  bp_global     [SLOT_COUNT];
    logic                  bp_used       [SLOT_COUNT];
    logic [SLOT_IDX_W-1:0] bp_free_stack [SLOT_COUNT];
    int                    bp_free_cnt;

    t_bp_resp pending_resp[$];
    t_bp_row  directed_rows[$];
    t_bp_resp oldest_resp;
    int       error_cnt = 0;
    int       cycle_cnt = 0;
    int       sender_idle_pct = 0;

    debug_breakpoint_slot_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_address     (i_address),
        .i_access_type (i_access_type),
        .i_size_code   (i_size_code),
        .i_scope       (i_scope),
        .i_slot        (i_slot),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Count failures; report only the first few
    function automatic void flag_error(string msg);
        error_cnt++;
        if (error_cnt <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    // Apply one command beat to the shadow table and return its result
    function automatic t_bp_resp bp_table_apply(t_bp_cmd c);
        t_bp_resp              r;
        logic [SLOT_IDX_W-1:0] s;
        bit                    found;
        r.status     = ST_OK;
        r.slot_index = '0;
        found        = 1'b0;
        case (c.opcode)
            OP_SET: begin
                if (c.size_code > SIZE_8B) begin
                    r.status = ST_BAD_SIZE;
                end else if (c.access_type > KIND_RW) begin
                    r.status = ST_BAD_TYPE;
                end else if (c.scope != SCOPE_LOCAL && c.scope != SCOPE_GLOBAL) begin
                    r.status = ST_BAD_SCOPE;
                end else if (bp_free_cnt == 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    bp_free_cnt--;
                    s = bp_free_stack[bp_free_cnt];
                    bp_used[s]     = 1'b1;
                    bp_base[s]     = c.address;
                    bp_kind[s]     = c.access_type[1:0];
                    bp_len_code[s] = c.size_code[1:0];
                    bp_global[s]   = (c.scope == SCOPE_GLOBAL);
                    r.slot_index   = s;
                end
            end
            OP_FIND: begin
                r.status = ST_NOT_FOUND;
                // Lowest matching slot wins; range end is taken without wrap
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!found && bp_used[i] && {1'b0, bp_kind[i]} == c.access_type &&
                        c.address >= bp_base[i] &&
                        (c.address - bp_base[i]) < (ADDR_W'(1) << bp_len_code[i])) begin
                        found        = 1'b1;
                        r.status     = ST_OK;
                        r.slot_index = SLOT_IDX_W'(i);
                    end
                end
            end
            OP_FREE: begin
                if (!bp_used[c.slot]) begin
                    r.status = ST_NOT_USED;
                end else begin
                    bp_used[c.slot]     = 1'b0;
                    bp_base[c.slot]     = '0;
                    bp_kind[c.slot]     = '0;
                    bp_len_code[c.slot] = '0;
                    bp_global[c.slot]   = 1'b0;
                    if (bp_free_cnt < SLOT_COUNT) begin
                        bp_free_stack[bp_free_cnt] = c.slot;
                        bp_free_cnt++;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic add_row(t_opcode op, logic [ADDR_W-1:0] addr, logic [2:0] kind,
                           logic [2:0] size, logic [1:0] scope, int slot,
                           bit fixed, t_status status, int idx);
        t_bp_row row;
        row.cmd.opcode        = op;
        row.cmd.address       = addr;
        row.cmd.access_type   = kind;
        row.cmd.size_code     = size;
        row.cmd.scope         = scope;
        row.cmd.slot          = SLOT_IDX_W'(slot);
        row.fixed             = fixed;
        row.resp.status       = status;
        row.resp.slot_index   = SLOT_IDX_W'(idx);
        directed_rows.push_back(row);
    endtask

    // Present one command beat, hold it until taken, then queue its result
    task automatic issue_cmd(t_bp_cmd c, bit fixed, t_bp_resp fixed_resp);
        t_bp_resp predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            start         = 1'b0;
            i_opcode      = 2'($urandom_range(3));
            i_address     = $urandom;
            i_access_type = 3'($urandom_range(7));
            i_size_code   = 3'($urandom_range(7));
            i_scope       = 2'($urandom_range(3));
            i_slot        = SLOT_IDX_W'($urandom_range(SLOT_COUNT - 1));
            @(negedge i_clk);
        end
        i_opcode      = c.opcode;
        i_address     = c.address;
        i_access_type = c.access_type;
        i_size_code   = c.size_code;
        i_scope       = c.scope;
        i_slot        = c.slot;
        start         = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = bp_table_apply(c);
        pending_resp.push_back(fixed ? fixed_resp : predicted);
        @(negedge i_clk);
    endtask

    // Check each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_resp.size() == 0) begin
                flag_error($sformatf("unexpected result status=%0d slot=%0d",
                                     o_status, o_slot_index));
            end else begin
                oldest_resp = pending_resp.pop_front();
                if (o_status !== oldest_resp.status) begin
                    flag_error($sformatf("status exp=%0d act=%0d",
                                         oldest_resp.status, o_status));
                end
                if (o_slot_index !== oldest_resp.slot_index) begin
                    flag_error($sformatf("slot_index exp=%0d act=%0d",
                                         oldest_resp.slot_index, o_slot_index));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[debug_breakpoint_slot_table_core] ERROR");
            $finish;
        end
    end

    initial begin
        t_bp_cmd  c;
        t_bp_resp none;
        int       pick;
        int       s;

        none          = '0;
        start         = 1'b0;
        i_rst_n       = 1'b0;
        i_opcode      = '0;
        i_address     = '0;
        i_access_type = '0;
        i_size_code   = '0;
        i_scope       = '0;
        i_slot        = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            bp_base[i]       = '0;
            bp_kind[i]       = '0;
            bp_len_code[i]   = '0;
            bp_global[i]     = 1'b0;
            bp_used[i]       = 1'b0;
            bp_free_stack[i] = SLOT_IDX_W'(i);
        end
        bp_free_cnt = SLOT_COUNT;

        // Directed rows: fresh table, error priority, top-of-space range, LIFO reuse
        add_row(OP_NOP,  '0,           KIND_EXEC,   SIZE_1B,     SCOPE_NONE,   0, 1, ST_OK, 0);
        add_row(OP_FIND, '0,           KIND_EXEC,   SIZE_1B,     SCOPE_LOCAL,  0, 1,
                ST_NOT_FOUND, 0);
        add_row(OP_FREE, '0,           KIND_EXEC,   SIZE_1B,     SCOPE_LOCAL,  0, 1,
                ST_NOT_USED, 0);
        add_row(OP_SET,  '0,           KIND_BAD_HI, SIZE_BAD_HI, SCOPE_NONE,   0, 1,
                ST_BAD_SIZE, 0);
        add_row(OP_SET,  '0,           KIND_BAD_LO, SIZE_8B,     SCOPE_BOTH,   0, 1,
                ST_BAD_TYPE, 0);
        add_row(OP_SET,  '0,           KIND_EXEC,   SIZE_1B,     SCOPE_NONE,   0, 1,
                ST_BAD_SCOPE, 0);
        add_row(OP_SET,  ADDR_TOP,     KIND_RW,     SIZE_8B,     SCOPE_BOTH,   0, 1,
                ST_BAD_SCOPE, 0);
        add_row(OP_SET,  32'hFFFF_FFFC, KIND_WRITE, SIZE_8B,     SCOPE_GLOBAL, 0, 1, ST_OK, 3);
        add_row(OP_FIND, ADDR_TOP,     KIND_WRITE,  SIZE_1B,     SCOPE_LOCAL,  0, 1, ST_OK, 3);
        add_row(OP_FIND, '0,           KIND_WRITE,  SIZE_1B,     SCOPE_LOCAL,  0, 1,
                ST_NOT_FOUND, 0);
        add_row(OP_FIND, ADDR_TOP,     KIND_BAD_MID, SIZE_1B,    SCOPE_LOCAL,  0, 1,
                ST_NOT_FOUND, 0);
        add_row(OP_SET,  '0,           KIND_EXEC,   SIZE_1B,     SCOPE_LOCAL,  0, 1, ST_OK, 2);
        add_row(OP_SET,  CLUSTER_BASE, KIND_IO,     SIZE_4B,     SCOPE_GLOBAL, 0, 0, ST_OK, 0);
        add_row(OP_SET,  CLUSTER_BASE + 2, KIND_IO, SIZE_2B,     SCOPE_LOCAL,  0, 0, ST_OK, 0);
        add_row(OP_SET,  CLUSTER_BASE, KIND_RW,     SIZE_1B,     SCOPE_LOCAL,  0, 1,
                ST_NO_FREE, 0);
        add_row(OP_FIND, CLUSTER_BASE + 3, KIND_IO, SIZE_1B,     SCOPE_LOCAL,  0, 0, ST_OK, 0);
        add_row(OP_FIND, CLUSTER_BASE + 4, KIND_IO, SIZE_1B,     SCOPE_LOCAL,  0, 0, ST_OK, 0);
        add_row(OP_FIND, '0,           KIND_EXEC,   SIZE_1B,     SCOPE_LOCAL,  0, 0, ST_OK, 0);
        add_row(OP_FIND, 32'd1,        KIND_EXEC,   SIZE_1B,     SCOPE_LOCAL,  0, 0, ST_OK, 0);
        add_row(OP_FREE, '0,           KIND_EXEC,   SIZE_1B,     SCOPE_LOCAL,  1, 0, ST_OK, 0);
        add_row(OP_FREE, '0,           KIND_EXEC,   SIZE_1B,     SCOPE_LOCAL,  1, 1,
                ST_NOT_USED, 0);
        add_row(OP_FREE, '0,           KIND_EXEC,   SIZE_1B,     SCOPE_LOCAL,  2, 0, ST_OK, 0);
        add_row(OP_SET,  32'h0000_ABCD, KIND_RW,    SIZE_2B,     SCOPE_LOCAL,  0, 0, ST_OK, 0);
        add_row(OP_FIND, CLUSTER_BASE, KIND_IO,     SIZE_1B,     SCOPE_LOCAL,  0, 0, ST_OK, 0);
        add_row(OP_NOP,  ADDR_TOP,     KIND_BAD_HI, SIZE_BAD_HI, SCOPE_BOTH,   3, 1, ST_OK, 0);

        // Hold reset, then release on a falling edge
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        sender_idle_pct = 19;
        foreach (directed_rows[k]) begin
            issue_cmd(directed_rows[k].cmd, directed_rows[k].fixed, directed_rows[k].resp);
        end

        // Random beats in three idle phases
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 48 : 0;
            repeat (RANDOM_ITEMS / 3) begin
                pick          = $urandom_range(99);
                c.opcode      = OP_FIND;
                c.address     = $urandom;
                c.access_type = 3'($urandom_range(7));
                c.size_code   = 3'($urandom_range(7));
                c.scope       = 2'($urandom_range(3));
                c.slot        = SLOT_IDX_W'($urandom_range(SLOT_COUNT - 1));
                if (pick < 25) begin
                    // well-formed set, bases clustered to get overlapping ranges
                    c.opcode      = OP_SET;
                    c.access_type = 3'($urandom_range(KIND_RW));
                    c.size_code   = 3'($urandom_range(SIZE_8B));
                    c.scope       = $urandom_range(1) ? SCOPE_GLOBAL : SCOPE_LOCAL;
                    s = $urandom_range(99);
                    if (s < 40) begin
                        c.address = CLUSTER_BASE + ADDR_W'($urandom_range(31));
                    end else if (s < 55) begin
                        c.address = ADDR_TOP - ADDR_W'($urandom_range(7));
                    end else if (s < 65) begin
                        c.address = ADDR_W'($urandom_range(7));
                    end
                end else if (pick < 33) begin
                    // set with raw fields, mostly rejected
                    c.opcode = OP_SET;
                end else if (pick < 63) begin
                    // find aimed around a stored range
                    s = $urandom_range(SLOT_COUNT - 1);
                    if ($urandom_range(9) != 0) begin
                        c.access_type = {1'b0, bp_kind[s]};
                    end
                    c.address = bp_base[s] + ADDR_W'($urandom_range(9)) - ADDR_W'(1);
                end else if (pick < 75) begin
                    // find with raw fields
                    c.opcode = OP_FIND;
                end else if (pick < 97) begin
                    // free, mostly of a slot in use
                    c.opcode = OP_FREE;
                    if ($urandom_range(4) != 0) begin
                        s = $urandom_range(SLOT_COUNT - 1);
                        for (int k = 0; k < SLOT_COUNT && !bp_used[s]; k++) begin
                            s = (s + 1) % SLOT_COUNT;
                        end
                        c.slot = SLOT_IDX_W'(s);
                    end
                end else begin
                    c.opcode = OP_NOP;
                end
                issue_cmd(c, 1'b0, none);
            end
        end

        // Drain outstanding results
        start = 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("[debug_breakpoint_slot_table_core] OK");
        end else begin
            $display("[debug_breakpoint_slot_table_core] ERROR");
        end
        $finish;
    end

endmodule
